>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is applied.
`define ASSERT_IMPLIES(lbl, clk_sig, rst_sig, ante, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!(rst_sig)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Implication after a fixed number of cycles.
`define ASSERT_AFTER(lbl, clk_sig, rst_sig, ante, n, cons) \
    lbl: assert property (@(posedge clk_sig) disable iff (!(rst_sig)) (ante) |-> ##n (cons)) \
        else $error("delayed implication check failed");

`endif

>>> hw/rtl/cdd_pkg.sv
`timescale 1ns / 1ps

package cdd_pkg;

    localparam int YEAR_BITS     = 12;
    localparam int CFG_YEAR_BITS = 12;
    localparam int DAY_BITS      = 5;
    localparam int MONTH_BITS    = 4;
    localparam int COUNT_BITS    = 21;
    localparam int ADDR_BITS     = 3;
    localparam int DATA_BITS     = 32;

    // Serial day numbers stay below 512 times the largest year.
    localparam int SERIAL_BITS = YEAR_BITS + 9;

    // Operand and quotient widths of the divide-by-100 unit.
    localparam int QX_BITS     = YEAR_BITS + 1;
    localparam int Q_BITS      = QX_BITS - 6;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_BITS  = 18;
    localparam int RECIP       = (2 ** RECIP_SHIFT + 99) / 100;

    localparam int COUNT_MAX  = 2 ** COUNT_BITS - 1;
    localparam int PIPE_DEPTH = 3;

    localparam logic [CFG_YEAR_BITS-1:0] EARLIEST_RESET = 12'd1850;
    localparam logic [CFG_YEAR_BITS-1:0] LATEST_RESET   = 12'd2050;

    // Register index, taken from paddr[2].
    localparam logic REG_EARLIEST = 1'b0;
    localparam logic REG_LATEST   = 1'b1;

    typedef enum logic [1:0] {
        ORDER_EQUAL  = 2'd0,
        ORDER_BEFORE = 2'd1,
        ORDER_AFTER  = 2'd2
    } order_t;

    typedef struct packed {
        logic [DAY_BITS-1:0]   first_day;
        logic [MONTH_BITS-1:0] first_month;
        logic [YEAR_BITS-1:0]  first_year;
        logic [DAY_BITS-1:0]   second_day;
        logic [MONTH_BITS-1:0] second_month;
        logic [YEAR_BITS-1:0]  second_year;
    } cdd_in_t;

    typedef struct packed {
        logic                  first_valid;
        logic                  second_valid;
        order_t                date_order;
        logic [COUNT_BITS-1:0] day_count;
    } cdd_out_t;

    typedef struct packed {
        logic [DAY_BITS-1:0]   day;
        logic [MONTH_BITS-1:0] month;
        logic [YEAR_BITS-1:0]  year;
    } date_t;

    typedef struct packed {
        logic                   valid;
        logic [SERIAL_BITS-1:0] serial;
    } date_info_t;

    typedef struct packed {
        logic [CFG_YEAR_BITS-1:0] earliest_year;
        logic [CFG_YEAR_BITS-1:0] latest_year;
    } cfg_t;

    // Quotient by 100 through a scaled reciprocal; exact for every operand width in use.
    function automatic logic [Q_BITS-1:0] div100(input logic [QX_BITS-1:0] x);
        logic [QX_BITS+RECIP_BITS-1:0] prod;
        prod = (QX_BITS + RECIP_BITS)'(x) * (QX_BITS + RECIP_BITS)'(RECIP);
        return prod[RECIP_SHIFT +: Q_BITS];
    endfunction

    // Days in a month; zero for codes that are no month, so no day can pass.
    function automatic logic [DAY_BITS-1:0] month_len(input logic [MONTH_BITS-1:0] m,
                                                     input logic leap);
        logic [DAY_BITS-1:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before(input logic [MONTH_BITS-1:0] m);
        logic [8:0] n;
        unique case (m)
            4'd2:    n = 9'd31;
            4'd3:    n = 9'd59;
            4'd4:    n = 9'd90;
            4'd5:    n = 9'd120;
            4'd6:    n = 9'd151;
            4'd7:    n = 9'd181;
            4'd8:    n = 9'd212;
            4'd9:    n = 9'd243;
            4'd10:   n = 9'd273;
            4'd11:   n = 9'd304;
            4'd12:   n = 9'd334;
            default: n = 9'd0;
        endcase
        return n;
    endfunction

endpackage

>>> hw/rtl/cdd_apb_regs.sv
`timescale 1ns / 1ps

module cdd_apb_regs
    import cdd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_EARLIEST: cfg_next.earliest_year = pwdata[CFG_YEAR_BITS-1:0];
                REG_LATEST:   cfg_next.latest_year   = pwdata[CFG_YEAR_BITS-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.earliest_year <= EARLIEST_RESET;
            cfg_reg.latest_year   <= LATEST_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_EARLIEST: prdata = DATA_BITS'(cfg_reg.earliest_year);
            REG_LATEST:   prdata = DATA_BITS'(cfg_reg.latest_year);
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> hw/rtl/cdd_date_unit.sv
`timescale 1ns / 1ps

module cdd_date_unit
    import cdd_pkg::*;
(
    input  logic       clk,
    input  logic       load1,
    input  logic       load2,
    input  date_t      date,
    input  cfg_t       cfg,
    output date_info_t info
);

    // First stage: the divisions by 100 and 400, the year times 365 and the window check.
    date_t                  date_reg;
    logic [SERIAL_BITS-1:0] y365_reg;
    logic [Q_BITS-1:0]      q100_reg;
    logic [Q_BITS-1:0]      q100c_reg;
    logic [Q_BITS-1:0]      q400c_reg;
    logic                   window_reg;
    date_info_t             info_reg;

    logic [QX_BITS-1:0]     year_x;
    logic [QX_BITS-1:0]     year_p399;
    logic                   in_window;

    assign year_x    = QX_BITS'(date.year);
    assign year_p399 = year_x + QX_BITS'(399);
    assign in_window = (date.year >= YEAR_BITS'(cfg.earliest_year))
                    && (date.year <= YEAR_BITS'(cfg.latest_year));

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            date_reg   <= date;
            y365_reg   <= SERIAL_BITS'(date.year) * SERIAL_BITS'(365);
            q100_reg   <= div100(year_x);
            q100c_reg  <= div100(year_x + QX_BITS'(99));
            q400c_reg  <= div100(year_p399 >> 2);
            window_reg <= in_window;
        end
    end

    // Second stage: leap rule, validity and the serial day number.
    logic                   exact100;
    logic                   leap;
    logic [DAY_BITS-1:0]    len;
    logic [QX_BITS-1:0]     quarter_up;
    date_info_t             info_next;

    assign exact100   = (QX_BITS'(q100_reg) * QX_BITS'(100)) == QX_BITS'(date_reg.year);
    assign leap       = (date_reg.year[1:0] == 2'b00) && (!exact100 || q100_reg[1:0] == 2'b00);
    assign len        = month_len(date_reg.month, leap);
    assign quarter_up = (QX_BITS'(date_reg.year) + QX_BITS'(3)) >> 2;

    always_comb
    begin
        info_next.valid  = window_reg && (date_reg.day != '0) && (date_reg.day <= len);
        info_next.serial = y365_reg
                         + SERIAL_BITS'(quarter_up)
                         - SERIAL_BITS'(q100c_reg)
                         + SERIAL_BITS'(q400c_reg)
                         + SERIAL_BITS'(days_before(date_reg.month))
                         + SERIAL_BITS'(leap && (date_reg.month > MONTH_BITS'(2)))
                         + SERIAL_BITS'(date_reg.day);
    end

    always_ff @(posedge clk)
    begin
        if (load2)
        begin
            info_reg <= info_next;
        end
    end

    assign info = info_reg;

endmodule

>>> hw/rtl/calendar_date_difference.sv
`timescale 1ns / 1ps

// Channel   | Ports                                         | Transaction
// ----------+-----------------------------------------------+------------------------------
// command   | start, busy, dates                            | start high and busy low
// result    | done, result                                  | done high, one cycle only
// config    | psel, penable, pwrite, paddr, pwdata, prdata, | psel, penable, pwrite high
//           | pready                                        | (pready is always high)
//
// A command may be issued in every cycle; busy never rises, as the pipeline never stops.
// Each result comes back through the pipeline stages: the reciprocal multipliers for the
// century divisions, the serial day adder, and the final subtraction.
// The receiver cannot stall the result, so no flow control runs backwards through the stages.
// An asynchronous reset clears the stage valid bits and loads the year window with its
// defaults of 1850 and 2050; the data registers are not reset.

module calendar_date_difference
    import cdd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cdd_in_t              dates,
    output logic                 done,
    output cdd_out_t             result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready
);

    cfg_t       cfg;
    date_t      first_date;
    date_t      second_date;
    date_info_t first_info;
    date_info_t second_info;

    logic       accept;
    logic       s1_valid_reg;
    logic       s2_valid_reg;
    logic       done_reg;
    order_t     order_next;
    order_t     order_s1_reg;
    order_t     order_s2_reg;
    cdd_out_t   result_reg;
    cdd_out_t   result_next;

    logic [SERIAL_BITS-1:0] diff;

    // The pipeline advances every cycle, so a command is always taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    cdd_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign first_date.day    = dates.first_day;
    assign first_date.month  = dates.first_month;
    assign first_date.year   = dates.first_year;
    assign second_date.day   = dates.second_day;
    assign second_date.month = dates.second_month;
    assign second_date.year  = dates.second_year;

    cdd_date_unit u_first (
        .clk   (clk),
        .load1 (accept),
        .load2 (s1_valid_reg),
        .date  (first_date),
        .cfg   (cfg),
        .info  (first_info)
    );

    cdd_date_unit u_second (
        .clk   (clk),
        .load1 (accept),
        .load2 (s1_valid_reg),
        .date  (second_date),
        .cfg   (cfg),
        .info  (second_info)
    );

    // Comparing year, month and day in turn is the same as one compare of the
    // concatenated fields, whether the dates are valid or not.
    always_comb
    begin
        priority if ({dates.first_year, dates.first_month, dates.first_day}
                     < {dates.second_year, dates.second_month, dates.second_day})
        begin
            order_next = ORDER_BEFORE;
        end
        else if ({dates.first_year, dates.first_month, dates.first_day}
                 > {dates.second_year, dates.second_month, dates.second_day})
        begin
            order_next = ORDER_AFTER;
        end
        else
        begin
            order_next = ORDER_EQUAL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            order_s1_reg <= order_next;
        end
        if (s1_valid_reg)
        begin
            order_s2_reg <= order_s1_reg;
        end
    end

    // Final stage: the count is only given for two valid dates in ascending order,
    // and it saturates at the largest value the result field can carry.
    assign diff = second_info.serial - first_info.serial;

    always_comb
    begin
        result_next.first_valid  = first_info.valid;
        result_next.second_valid = second_info.valid;
        result_next.date_order   = order_s2_reg;
        result_next.day_count    = '0;
        if (first_info.valid && second_info.valid && (order_s2_reg == ORDER_BEFORE))
        begin
            if (diff > SERIAL_BITS'(COUNT_MAX))
            begin
                result_next.day_count = COUNT_BITS'(COUNT_MAX);
            end
            else
            begin
                result_next.day_count = diff[COUNT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> hw/rtl/cdd_checker.sv
`timescale 1ns / 1ps

`include "assert_macros.svh"

module cdd_checker
    import cdd_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input cdd_in_t  dates,
    input logic     done,
    input cdd_out_t result
);

    logic cmd_taken;
    logic count_given;

    assign cmd_taken   = start && !busy;
    assign count_given = done && (result.day_count != '0);

    // Every command yields one result a fixed time later, and no result comes without one.
    `ASSERT_AFTER(a_result_follows, clk, rst_n, cmd_taken, PIPE_DEPTH, done)
    `ASSERT_IMPLIES(a_no_stray_result, clk, rst_n, done, $past(cmd_taken, PIPE_DEPTH))
    // A nonzero count needs two valid dates in ascending order.
    `ASSERT_IMPLIES(a_count_needs_order, clk, rst_n, count_given,
                    result.first_valid && result.second_valid
                    && (result.date_order == ORDER_BEFORE))
    // Identical dates are never reported as different.
    `ASSERT_IMPLIES(a_equal_dates, clk, rst_n,
                    done && $past(cmd_taken && (dates.first_day == dates.second_day)
                                  && (dates.first_month == dates.second_month)
                                  && (dates.first_year == dates.second_year), PIPE_DEPTH),
                    result.date_order == ORDER_EQUAL)

endmodule

bind calendar_date_difference cdd_checker u_cdd_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .dates  (dates),
    .done   (done),
    .result (result)
);

>>> sim/date_difference_checker.sv
`timescale 1ns / 1ps

module date_difference_checker
    import cdd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  cdd_in_t              dates,
    input  logic                 done,
    input  cdd_out_t             result,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic                 pready,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output int                   mismatches,
    output int                   outstanding
);

    // The year window as this checker believes the block holds it.
    logic [CFG_YEAR_BITS-1:0] window_low;
    logic [CFG_YEAR_BITS-1:0] window_high;

    cdd_out_t pending_results[$];
    cdd_out_t oldest;
    int       failures = 0;

    initial mismatches = 0;
    initial outstanding = 0;

    function automatic bit leap_year(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in_month(int m, int y);
        case (m)
            2:                     return leap_year(y) ? 29 : 28;
            4, 6, 9, 11:           return 30;
            1, 3, 5, 7, 8, 10, 12: return 31;
            default:               return 0;
        endcase
    endfunction

    function automatic bit date_in_window(int d, int m, int y);
        return (y >= int'(window_low)) && (y <= int'(window_high)) && (d >= 1)
            && (d <= days_in_month(m, y));
    endfunction

    // Day number from the start of year zero, 1 January of year zero being day 1; only meaningful for valid dates.
    function automatic int day_number(int d, int m, int y);
        int n;
        n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + d;
        for (int k = 1; k < m; k++)
            n += days_in_month(k, y);
        return n;
    endfunction

    function automatic cdd_out_t predict_difference(cdd_in_t c);
        cdd_out_t r;
        int       span;
        r.first_valid  = date_in_window(c.first_day, c.first_month, c.first_year);
        r.second_valid = date_in_window(c.second_day, c.second_month, c.second_year);
        // The order is taken from the raw fields, valid or not.
        if (c.first_year != c.second_year)
            r.date_order = (c.first_year < c.second_year) ? ORDER_BEFORE : ORDER_AFTER;
        else if (c.first_month != c.second_month)
            r.date_order = (c.first_month < c.second_month) ? ORDER_BEFORE : ORDER_AFTER;
        else if (c.first_day != c.second_day)
            r.date_order = (c.first_day < c.second_day) ? ORDER_BEFORE : ORDER_AFTER;
        else
            r.date_order = ORDER_EQUAL;
        r.day_count = '0;
        if (r.first_valid && r.second_valid && r.date_order == ORDER_BEFORE)
        begin
            span = day_number(c.second_day, c.second_month, c.second_year)
                 - day_number(c.first_day, c.first_month, c.first_year);
            r.day_count = (span > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX) : COUNT_BITS'(span);
        end
        return r;
    endfunction

    task automatic log_failure(input string what);
        failures++;
        if (failures <= 10)
            $display("[%0t] %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            window_low  = EARLIEST_RESET;
            window_high = LATEST_RESET;
            pending_results.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[2])
                    REG_EARLIEST: window_low  = pwdata[CFG_YEAR_BITS-1:0];
                    REG_LATEST:   window_high = pwdata[CFG_YEAR_BITS-1:0];
                    default:      ;
                endcase
            end
            // Pushed before the result is popped so that the oldest is always compared.
            if (start && !busy)
                pending_results.push_back(predict_difference(dates));
            if (done)
            begin
                if (pending_results.size() == 0)
                    log_failure($sformatf("result transaction with none expected: %0b %0b %0d %0d",
                                          result.first_valid, result.second_valid,
                                          result.date_order, result.day_count));
                else
                begin
                    oldest = pending_results.pop_front();
                    if (result.first_valid !== oldest.first_valid
                        || result.second_valid !== oldest.second_valid
                        || result.date_order !== oldest.date_order
                        || result.day_count !== oldest.day_count)
                        log_failure($sformatf({"result mismatch: expected valid %0b/%0b ",
                                               "order %0d count %0d, got valid %0b/%0b ",
                                               "order %0d count %0d"},
                                              oldest.first_valid, oldest.second_valid,
                                              oldest.date_order, oldest.day_count,
                                              result.first_valid, result.second_valid,
                                              result.date_order, result.day_count));
                end
            end
        end
        mismatches  <= failures;
        outstanding <= pending_results.size();
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

// Stimulus for the date difference block. Dates go in through the command channel, the year
// window is set through the APB port, and a separate checker predicts and compares every
// result. This module only makes stimulus and gives the verdict.
module tb_top;
    import cdd_pkg::*;

    // Cycles without any transaction before the run is declared hung. The slowest honest gap
    // is a long run of sender idles plus the three pipeline stages, far below this.
    localparam int QUIET_LIMIT = 2000;

    localparam logic [ADDR_BITS-1:0] EARLIEST_ADDR = {REG_EARLIEST, 2'b00};
    localparam logic [ADDR_BITS-1:0] LATEST_ADDR   = {REG_LATEST, 2'b00};

    logic                 clk     = 1'b0;
    logic                 rst_n   = 1'b0;
    logic                 start   = 1'b0;
    logic                 busy;
    cdd_in_t              dates   = '0;
    logic                 done;
    cdd_out_t             result;
    logic                 psel    = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr   = '0;
    logic [DATA_BITS-1:0] pwdata  = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;

    int mismatches;
    int outstanding;

    // The window that the stimulus aims at; the checker tracks its own copy from the bus.
    int lo_year  = EARLIEST_RESET;
    int hi_year  = LATEST_RESET;
    int idle_pct = 0;
    int quiet_cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    calendar_date_difference u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .dates   (dates),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    date_difference_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .dates       (dates),
        .done        (done),
        .result      (result),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Watchdog: any accepted transaction on any channel resets the count.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (psel && penable && pwrite && pready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Watchdog expired after %0d cycles without a transaction", QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic cdd_in_t pair_of_dates(int d1, int m1, int y1, int d2, int m2, int y2);
        cdd_in_t c;
        c.first_day    = DAY_BITS'(d1);
        c.first_month  = MONTH_BITS'(m1);
        c.first_year   = YEAR_BITS'(y1);
        c.second_day   = DAY_BITS'(d2);
        c.second_month = MONTH_BITS'(m2);
        c.second_year  = YEAR_BITS'(y2);
        return c;
    endfunction

    // Mostly well-formed dates inside the current window, with a share of dates just outside
    // it, days one past the end of their month, and raw noise over every field bit.
    function automatic date_t random_date();
        date_t x;
        int    kind;
        int    last_day;
        bit    leap;
        kind = $urandom_range(99);
        if (kind < 12)
        begin
            x.day   = DAY_BITS'($urandom);
            x.month = MONTH_BITS'($urandom);
            x.year  = YEAR_BITS'($urandom);
        end
        else
        begin
            if (kind < 18)
                x.year = YEAR_BITS'(kind[0] ? lo_year - 1 : hi_year + 1);
            else if (lo_year <= hi_year)
                x.year = YEAR_BITS'($urandom_range(hi_year, lo_year));
            else
                x.year = YEAR_BITS'($urandom);
            x.month = MONTH_BITS'($urandom_range(12, 1));
            leap = ((x.year % 4 == 0) && (x.year % 100 != 0)) || (x.year % 400 == 0);
            case (x.month)
                2:           last_day = leap ? 29 : 28;
                4, 6, 9, 11: last_day = 30;
                default:     last_day = 31;
            endcase
            if (kind < 22)
                x.day = DAY_BITS'(last_day + 1);
            else if (kind < 30)
                x.day = DAY_BITS'(kind[0] ? last_day : 1);
            else
                x.day = DAY_BITS'($urandom_range(last_day, 1));
        end
        return x;
    endfunction

    function automatic cdd_in_t random_pair();
        date_t a;
        date_t b;
        a = random_date();
        b = random_date();
        // Pull the second date close to the first now and then, so that equal dates and
        // orders decided by month or day turn up often.
        case ($urandom_range(9))
            0:
                b = a;
            1:
            begin
                b.year  = a.year;
                b.month = a.month;
            end
            2, 3:
                b.year = a.year;
            default:
                ;
        endcase
        // date_t and the command payload share one field order, first date on top.
        return {a, b};
    endfunction

    // One command transaction, after a random number of idle cycles. While idle the payload
    // carries junk, which the block must ignore without start.
    task automatic send_dates(input cdd_in_t item);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            dates <= $bits(cdd_in_t)'({$urandom, $urandom});
            @(posedge clk);
        end
        start <= 1'b1;
        dates <= item;
        do @(posedge clk); while (busy);
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Setup then access phase. Back-to-back writes go straight from access to the next setup,
    // so the select is only lowered by the caller once the last write is done.
    task automatic write_reg(input logic [ADDR_BITS-1:0] addr,
                             input logic [CFG_YEAR_BITS-1:0] year);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {(DATA_BITS - CFG_YEAR_BITS)'($urandom), year};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic set_window(input int low, input int high);
        drain_results();
        write_reg(EARLIEST_ADDR, CFG_YEAR_BITS'(low));
        write_reg(LATEST_ADDR, CFG_YEAR_BITS'(high));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        lo_year = low;
        hi_year = high;
    endtask

    initial
    begin
        int items;
        int low;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Phases of the year window. The sender idles lightly at first, then heavily, and
        // finally not at all. Each window change waits for the pipeline to empty first.
        for (int phase = 0; phase < 9; phase++)
        begin
            idle_pct = (phase < 4) ? 14 : (phase < 7) ? 55 : 0;
            case (phase)
                0:
                begin
                    // Reset window of 1850 to 2050.
                    send_dates(pair_of_dates(15, 6, 1990, 15, 6, 1990));
                    send_dates(pair_of_dates(1, 1, 1850, 31, 12, 2050));
                    send_dates(pair_of_dates(31, 12, 2050, 1, 1, 1850));
                    send_dates(pair_of_dates(28, 2, 2000, 1, 3, 2000));
                    send_dates(pair_of_dates(29, 2, 1900, 1, 3, 1900));
                    send_dates(pair_of_dates(29, 2, 2004, 29, 2, 2008));
                    send_dates(pair_of_dates(29, 2, 2001, 1, 3, 2001));
                    send_dates(pair_of_dates(1, 0, 2000, 1, 1, 2000));
                    send_dates(pair_of_dates(1, 13, 2000, 1, 1, 2001));
                    send_dates(pair_of_dates(31, 15, 4095, 31, 15, 4095));
                    send_dates(pair_of_dates(0, 0, 0, 0, 0, 0));
                    send_dates(pair_of_dates(0, 5, 2000, 1, 5, 2000));
                    send_dates(pair_of_dates(31, 4, 2000, 1, 5, 2000));
                    send_dates(pair_of_dates(31, 1, 2000, 31, 3, 2000));
                    send_dates(pair_of_dates(31, 12, 1849, 1, 1, 1850));
                    send_dates(pair_of_dates(31, 12, 2050, 1, 1, 2051));
                    send_dates(pair_of_dates(10, 3, 2020, 5, 3, 2020));
                    send_dates(pair_of_dates(1, 7, 2020, 1, 3, 2020));
                    send_dates(pair_of_dates(5, 5, 1999, 20, 5, 1999));
                    // Invalid dates still get an order from their raw fields.
                    send_dates(pair_of_dates(1, 13, 2001, 1, 1, 2000));
                    items = 100;
                end
                1:
                begin
                    // Widest window: the largest possible day count, and year zero as a leap
                    // year.
                    set_window(0, 4095);
                    send_dates(pair_of_dates(1, 1, 0, 31, 12, 4095));
                    send_dates(pair_of_dates(29, 2, 0, 29, 2, 4000));
                    items = 150;
                end
                2:
                begin
                    // Empty window: earliest above latest, so no year is valid.
                    set_window(2050, 1850);
                    items = 60;
                end
                3:
                begin
                    set_window(2000, 2000);
                    items = 80;
                end
                4:
                begin
                    set_window(0, 0);
                    items = 60;
                end
                5:
                begin
                    set_window(4095, 4095);
                    items = 60;
                end
                6, 7:
                begin
                    low = $urandom_range(3000);
                    set_window(low, low + $urandom_range(1095));
                    items = 140;
                end
                default:
                begin
                    set_window(1600, 2400);
                    items = 100;
                end
            endcase
            repeat (items)
                send_dates(random_pair());
        end

        // Let the last results through, then allow a few cycles for anything stray.
        drain_results();
        repeat (PIPE_DEPTH + 4) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/cdd_pkg.sv
hw/rtl/cdd_apb_regs.sv
hw/rtl/cdd_date_unit.sv
hw/rtl/calendar_date_difference.sv
hw/rtl/cdd_checker.sv
sim/date_difference_checker.sv
sim/tb_top.sv
